// ===== src/olist_pkg.sv =====
`timescale 1ns / 1ps
package olist_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_FIND   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_POP,
    S_POP_CAP,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    action_t            action;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               found;
    status_t            status;
    logic [4:0]         count;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic push;
    logic pop_rd;
    logic pop_cap;
    logic scan;
    logic set_found;
    logic shift_wr;
    logic del_done;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    empty;
    logic    hit;
    logic    more;
    logic    rd_vld;
    logic    out_free;
  } sts_t;

endpackage

// ===== src/olist_ctrl.sv =====
`timescale 1ns / 1ps
module olist_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  olist_pkg::action_t action,
  output logic               req_stall,
  input  olist_pkg::sts_t    sts,
  output olist_pkg::cmd_t    cmd
);

  olist_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= olist_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      olist_pkg::S_IDLE: begin
        if (req_valid) begin
          case (action)
            olist_pkg::ACT_PUSH: state_next = olist_pkg::S_PUSH;
            olist_pkg::ACT_POP:  state_next = olist_pkg::S_POP;
            default:             state_next = olist_pkg::S_SCAN;
          endcase
        end
      end
      olist_pkg::S_PUSH: state_next = olist_pkg::S_DONE;
      olist_pkg::S_POP: begin
        state_next = sts.empty ? olist_pkg::S_DONE : olist_pkg::S_POP_CAP;
      end
      olist_pkg::S_POP_CAP: state_next = olist_pkg::S_DONE;
      olist_pkg::S_SCAN: begin
        if (sts.hit) begin
          state_next = (sts.act == olist_pkg::ACT_FIND) ? olist_pkg::S_DONE
                                                        : olist_pkg::S_SHIFT;
        end else if (!sts.more && !sts.rd_vld) begin
          state_next = olist_pkg::S_DONE;
        end
      end
      olist_pkg::S_SHIFT: begin
        if (!sts.more && !sts.rd_vld) begin
          state_next = olist_pkg::S_DONE;
        end
      end
      olist_pkg::S_DONE: begin
        if (sts.out_free) begin
          state_next = olist_pkg::S_IDLE;
        end
      end
      default: state_next = olist_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = (state != olist_pkg::S_IDLE);
    case (state)
      olist_pkg::S_IDLE:    cmd.start   = req_valid;
      olist_pkg::S_PUSH:    cmd.push    = 1'b1;
      olist_pkg::S_POP:     cmd.pop_rd  = 1'b1;
      olist_pkg::S_POP_CAP: cmd.pop_cap = 1'b1;
      olist_pkg::S_SCAN: begin
        // keep reading on a hit: the next entry is what the shift needs first
        cmd.scan      = 1'b1;
        cmd.set_found = sts.hit;
      end
      olist_pkg::S_SHIFT: begin
        cmd.scan     = 1'b1;
        cmd.shift_wr = 1'b1;
        cmd.del_done = !sts.more && !sts.rd_vld;
      end
      olist_pkg::S_DONE:    cmd.load_out = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ===== src/olist_dp.sv =====
`timescale 1ns / 1ps
module olist_dp (
  input  logic            clk,
  input  logic            rst,
  input  olist_pkg::req_t req,
  input  olist_pkg::cmd_t cmd,
  output olist_pkg::sts_t sts,
  input  logic            rsp_stall,
  output logic            rsp_valid,
  output olist_pkg::rsp_t rsp
);

  logic [olist_pkg::WORD_BITS-1:0] mem [olist_pkg::DEPTH];

  olist_pkg::action_t              act;
  logic [olist_pkg::WORD_BITS-1:0] word;
  logic [olist_pkg::CNT_BITS-1:0]  cnt;
  logic [olist_pkg::CNT_BITS-1:0]  idx;
  logic [olist_pkg::CNT_BITS-1:0]  rd_idx;
  logic                            rd_vld;
  logic [olist_pkg::WORD_BITS-1:0] rd_data;
  logic signed [31:0]              res;
  logic                            found;
  olist_pkg::status_t              status;
  logic                            out_vld;
  olist_pkg::rsp_t                 out;

  logic                            full;
  logic                            empty;
  logic                            more;
  logic                            hit;
  logic [olist_pkg::CNT_BITS-1:0]  cnt_m1;
  logic [olist_pkg::CNT_BITS-1:0]  rd_idx_m1;
  logic                            rd_en;
  logic [olist_pkg::IDX_BITS-1:0]  rd_addr;
  logic                            wr_en;
  logic [olist_pkg::IDX_BITS-1:0]  wr_addr;
  logic [olist_pkg::WORD_BITS-1:0] wr_data;

  assign full      = (cnt >= olist_pkg::CNT_BITS'(olist_pkg::DEPTH));
  assign empty     = (cnt == '0);
  assign more      = (idx < cnt);
  assign hit       = rd_vld && (rd_data == word);
  assign cnt_m1    = cnt - olist_pkg::CNT_BITS'(1);
  assign rd_idx_m1 = rd_idx - olist_pkg::CNT_BITS'(1);

  assign rd_en   = (cmd.pop_rd && !empty) || (cmd.scan && more);
  assign rd_addr = cmd.pop_rd ? cnt_m1[olist_pkg::IDX_BITS-1:0]
                              : idx[olist_pkg::IDX_BITS-1:0];
  // shift moves the entry just read one place toward the head
  assign wr_en   = (cmd.push && !full) || (cmd.shift_wr && rd_vld);
  assign wr_addr = cmd.push ? cnt[olist_pkg::IDX_BITS-1:0]
                            : rd_idx_m1[olist_pkg::IDX_BITS-1:0];
  assign wr_data = cmd.push ? word : rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      rd_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.scan && more;
      if (cmd.push && !full) begin
        cnt <= cnt + olist_pkg::CNT_BITS'(1);
      end else if ((cmd.pop_rd && !empty) || cmd.del_done) begin
        cnt <= cnt_m1;
      end
      if (cmd.load_out) begin
        out_vld <= 1'b1;
      end else if (!rsp_stall) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      act    <= req.action;
      word   <= olist_pkg::WORD_BITS'(req.value);
      idx    <= '0;
      found  <= 1'b0;
      status <= olist_pkg::ST_OK;
      res    <= '0;
    end
    if (cmd.scan && more) begin
      idx    <= idx + olist_pkg::CNT_BITS'(1);
      rd_idx <= idx;
    end
    if (cmd.push && full) begin
      status <= olist_pkg::ST_FULL;
    end
    if (cmd.pop_rd && empty) begin
      status <= olist_pkg::ST_EMPTY;
    end
    if (cmd.pop_cap) begin
      res <= 32'(signed'(rd_data));
    end
    if (cmd.set_found) begin
      found <= 1'b1;
    end
    if (cmd.load_out) begin
      out.result_value <= res;
      out.found        <= found;
      out.status       <= status;
      out.count        <= 5'(cnt);
    end
  end

  assign sts.act      = act;
  assign sts.empty    = empty;
  assign sts.hit      = hit;
  assign sts.more     = more;
  assign sts.rd_vld   = rd_vld;
  assign sts.out_free = !out_vld || !rsp_stall;

  assign rsp_valid = out_vld;
  assign rsp       = out;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= olist_pkg::CNT_BITS'(olist_pkg::DEPTH))
    else $error("entry count above depth");

  a_push_inc: assert property (@(posedge clk) disable iff (rst)
    cmd.push && !full |=> cnt == $past(cnt) + olist_pkg::CNT_BITS'(1))
    else $error("push did not grow the list");

  a_shift_addr: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_wr && rd_vld |-> rd_idx != '0 && rd_idx < cnt)
    else $error("shift write outside the list");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !out_vld || !rsp_stall)
    else $error("result register overwritten while stalled");
`endif

endmodule

// ===== src/ordered_list_engine.sv =====
`timescale 1ns / 1ps
// A pop on an empty list skips its capture state. Find and delete scan the entry
// memory, which has one read and one write port, one entry per cycle; a find stops
// at its first hit, and a scan of an empty list reads no entries.
// Delete scans up to the match, then shifts later entries up one per cycle.
// One item at a time; the next beat is accepted in the cycle after the result loads.
// Synchronous active-high rst empties the list; entry storage is not cleared.
module ordered_list_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  olist_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output olist_pkg::rsp_t rsp
);

  olist_pkg::cmd_t cmd;
  olist_pkg::sts_t sts;

  olist_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .action    (req.action),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  olist_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

// ===== tb/olist_checker.sv =====
`timescale 1ns / 1ps
module olist_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            req_stall,
  input  olist_pkg::req_t req,
  input  logic            rsp_valid,
  input  logic            rsp_stall,
  input  olist_pkg::rsp_t rsp,
  output int              errors,
  output int              pending,
  output int              checked
);

  logic signed [31:0] stored_words[$];
  olist_pkg::rsp_t    expected_rsp[$];

  // Applies one action to the list copy and returns the result it should produce.
  function automatic olist_pkg::rsp_t apply_action(olist_pkg::req_t r);
    olist_pkg::rsp_t o;
    int              hit_idx;
    o = '0;
    o.status = olist_pkg::ST_OK;
    hit_idx = -1;
    if (r.action == olist_pkg::ACT_DELETE || r.action == olist_pkg::ACT_FIND) begin
      for (int i = 0; i < stored_words.size(); i++) begin
        if (hit_idx < 0 && stored_words[i] == r.value) hit_idx = i;
      end
    end
    case (r.action)
      olist_pkg::ACT_PUSH: begin
        if (stored_words.size() >= olist_pkg::DEPTH) o.status = olist_pkg::ST_FULL;
        else stored_words.push_back(r.value);
      end
      olist_pkg::ACT_POP: begin
        if (stored_words.size() == 0) o.status = olist_pkg::ST_EMPTY;
        else o.result_value = stored_words.pop_back();
      end
      olist_pkg::ACT_DELETE: begin
        if (hit_idx >= 0) begin
          o.found = 1'b1;
          stored_words.delete(hit_idx);
        end
      end
      default: begin
        o.found = (hit_idx >= 0);
      end
    endcase
    o.count = 5'(stored_words.size());
    return o;
  endfunction

  always @(posedge clk) begin
    olist_pkg::rsp_t want;
    int              bad;
    bad = 0;
    if (rst) begin
      stored_words.delete();
      expected_rsp.delete();
    end else begin
      if (req_valid && !req_stall) expected_rsp.push_back(apply_action(req));
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected result beat: value %0d found %0d status %0d count %0d",
                   $time, rsp.result_value, rsp.found, rsp.status, rsp.count);
          bad = 1;
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.result_value !== want.result_value) begin
            $display("%0t: result_value expected %0d actual %0d",
                     $time, want.result_value, rsp.result_value);
            bad++;
          end
          if (rsp.found !== want.found) begin
            $display("%0t: found expected %0d actual %0d", $time, want.found, rsp.found);
            bad++;
          end
          if (rsp.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
            bad++;
          end
          if (rsp.count !== want.count) begin
            $display("%0t: count expected %0d actual %0d", $time, want.count, rsp.count);
            bad++;
          end
        end
        checked <= checked + 1;
      end
    end
    errors  <= errors + bad;
    pending <= expected_rsp.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int NUM_RANDOM = 1530;
  localparam int QUIET_TAIL = 200;
  localparam int LIMIT      = 600000;

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            req_valid = 1'b0;
  logic            rsp_stall = 1'b0;
  olist_pkg::req_t req       = '0;
  logic            req_stall;
  logic            rsp_valid;
  olist_pkg::rsp_t rsp;

  int errors;
  int pending;
  int checked;
  int cycles     = 0;
  int stall_left = 0;
  int act_count[4];
  bit quiet      = 1'b0;

  logic signed [31:0]   value_pool[8];
  int                   mode;
  int                   roll;
  olist_pkg::action_t   act;

  ordered_list_engine DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  olist_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver stalls in random bursts; none during reset or the quiet tail.
  always @(posedge clk) begin
    if (rst || quiet) begin
      rsp_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 12);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  task automatic send_beat(olist_pkg::action_t a, logic signed [31:0] v);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req_valid  <= 1'b1;
    req.action <= a;
    req.value  <= v;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    act_count[a]++;
  endtask

  // Mostly values from a small pool so find and delete hit often.
  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return value_pool[$urandom_range(0, 7)];
    if (r < 9) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'sh0;
      default: return -32'sd1;
    endcase
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // operations on an empty list
    send_beat(olist_pkg::ACT_POP, 32'sh12345678);
    send_beat(olist_pkg::ACT_FIND, 32'sh0);
    send_beat(olist_pkg::ACT_DELETE, 32'sh0);
    // extremes, with a duplicate of the first value
    send_beat(olist_pkg::ACT_PUSH, 32'sh7FFFFFFF);
    send_beat(olist_pkg::ACT_PUSH, 32'sh80000000);
    send_beat(olist_pkg::ACT_PUSH, 32'sh0);
    send_beat(olist_pkg::ACT_PUSH, -32'sd1);
    send_beat(olist_pkg::ACT_PUSH, 32'sh7FFFFFFF);
    send_beat(olist_pkg::ACT_FIND, 32'sh80000000);
    send_beat(olist_pkg::ACT_FIND, 32'sh7FFFFFFF);
    send_beat(olist_pkg::ACT_FIND, 32'sd5);
    send_beat(olist_pkg::ACT_DELETE, 32'sh7FFFFFFF);  // head, duplicate stays
    send_beat(olist_pkg::ACT_DELETE, 32'sh0);         // middle
    send_beat(olist_pkg::ACT_DELETE, 32'sh7FFFFFFF);  // tail
    send_beat(olist_pkg::ACT_DELETE, 32'sd7);         // no match
    send_beat(olist_pkg::ACT_FIND, 32'sh7FFFFFFF);
    send_beat(olist_pkg::ACT_PUSH, 32'sh5A5AA5A5);
    send_beat(olist_pkg::ACT_POP, 32'sh0);
    send_beat(olist_pkg::ACT_POP, -32'sd1);
    send_beat(olist_pkg::ACT_POP, 32'sh0);
    send_beat(olist_pkg::ACT_POP, 32'sh0);            // empty again

    for (int k = 0; k < 8; k++) value_pool[k] = $urandom;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      quiet = (i >= NUM_RANDOM - QUIET_TAIL);
      if (i % 97 == 0) value_pool[$urandom_range(0, 7)] = $urandom;
      // phases lean toward filling, churning, or draining the list
      mode = (i / 60) % 3;
      roll = $urandom_range(0, 99);
      case (mode)
        0: act = (roll < 55) ? olist_pkg::ACT_PUSH : (roll < 70) ? olist_pkg::ACT_POP :
                 (roll < 85) ? olist_pkg::ACT_DELETE : olist_pkg::ACT_FIND;
        1: act = (roll < 25) ? olist_pkg::ACT_PUSH : (roll < 50) ? olist_pkg::ACT_POP :
                 (roll < 75) ? olist_pkg::ACT_DELETE : olist_pkg::ACT_FIND;
        default: act = (roll < 15) ? olist_pkg::ACT_PUSH :
                       (roll < 55) ? olist_pkg::ACT_POP :
                       (roll < 80) ? olist_pkg::ACT_DELETE : olist_pkg::ACT_FIND;
      endcase
      send_beat(act, pick_value());
    end
    req_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("sent %0d beats: push %0d, pop %0d, delete %0d, find %0d",
             act_count[olist_pkg::ACT_PUSH] + act_count[olist_pkg::ACT_POP] +
             act_count[olist_pkg::ACT_DELETE] + act_count[olist_pkg::ACT_FIND],
             act_count[olist_pkg::ACT_PUSH], act_count[olist_pkg::ACT_POP],
             act_count[olist_pkg::ACT_DELETE], act_count[olist_pkg::ACT_FIND]);
    $display("%0d result beats compared, %0d mismatches", checked, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== ordered_list_engine.f =====
src/olist_pkg.sv
src/olist_ctrl.sv
src/olist_dp.sv
src/ordered_list_engine.sv
tb/olist_checker.sv
tb/tb_top.sv
